### hdl/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types, character codes and elaboration helpers for the decimal
// ASCII printer.
// ----------------------------------------------------------------------------
package ida_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 32;
	localparam int VALUE_FIELD_W       = 32;
	localparam int CHAR_W              = 8;
	localparam int RADIX               = 10;
	localparam int DIGIT_W             = 4;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic neg;
		logic nl;
	} ida_flags_t;

	localparam int FLAGS_W = $bits(ida_flags_t);

	function automatic logic [127:0] ida_pow10(int k);
		logic [127:0] p;
		p = 128'd1;
		for (int i = 0; i < 40; i++) begin
			if (i < k) begin
				p = p * 128'd10;
			end
		end
		return p;
	endfunction

	function automatic int ida_num_digits(int vw);
		logic [127:0] lim;
		logic [127:0] p;
		int n;
		lim = (128'd1 << vw) - 128'd1;
		p = 128'd1;
		n = 0;
		for (int i = 0; i < 40; i++) begin
			if (p <= lim) begin
				n++;
				p = p * 128'd10;
			end
		end
		return n;
	endfunction

endpackage

### hdl/ida_front.sv
// ----------------------------------------------------------------------------
// ida_front
// Accepts a transaction, takes the magnitude and sign of the value and holds
// the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module ida_front import ida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [VALUE_FIELD_W-1:0] value,
	input  logic                     is_signed,
	input  logic                     add_newline,
	input  logic                     q_full,
	output logic                     push,
	output logic [VALUE_WIDTH-1:0]   mag,
	output ida_flags_t               flags
);

	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	ida_flags_t             flags_s1;
	logic [VALUE_WIDTH-1:0] v;
	logic                   neg;
	logic                   accept;

	assign v      = VALUE_WIDTH'(value);
	assign neg    = is_signed & v[VALUE_WIDTH-1];
	assign push   = valid_s1 & ~q_full;
	assign busy   = valid_s1 & q_full;
	assign accept = start & ~busy;
	assign mag    = mag_s1;
	assign flags  = flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mag_s1   <= '0;
			flags_s1 <= '0;
		end else if (accept) begin
			valid_s1     <= 1'b1;
			mag_s1       <= neg ? (~v + 1'b1) : v;
			flags_s1.neg <= neg;
			flags_s1.nl  <= add_newline;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

### hdl/ida_queue.sv
// ----------------------------------------------------------------------------
// ida_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module ida_queue import ida_pkg::*; #(
	parameter int DATA_W = DEFAULT_VALUE_WIDTH + FLAGS_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/ida_back.sv
// ----------------------------------------------------------------------------
// ida_back
// Character sequencer: sign, one decimal position per cycle from the top
// with leading zeros dropped, then the optional line ending.
// ----------------------------------------------------------------------------
module ida_back import ida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	input  ida_flags_t             q_flags,
	output logic                   pop,
	output logic [CHAR_W-1:0]      ch,
	output logic                   last,
	output logic                   strobe
);

	localparam int NDIG  = ida_num_digits(VALUE_WIDTH);
	localparam int PW    = VALUE_WIDTH + 4;
	localparam int POS_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [POS_W-1:0] TOP_POS = POS_W'(NDIG - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIGIT,
		ST_LF,
		ST_CR
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [POS_W-1:0]       pos_q;
	logic                   started_q;
	logic                   nl_q;
	logic [CHAR_W-1:0]      ch_q;
	logic                   last_q;
	logic                   strobe_q;

	logic [PW-1:0]          mult_tbl [NDIG][RADIX];
	logic [PW:0]            diff     [RADIX];
	logic [PW-1:0]          rem_ext;
	logic [DIGIT_W-1:0]     digit;
	logic [VALUE_WIDTH-1:0] rem_next;
	logic                   at_bottom;
	logic                   emit;

	for (genvar k = 0; k < NDIG; k++) begin : g_pos
		for (genvar m = 0; m < RADIX; m++) begin : g_mult
			assign mult_tbl[k][m] = PW'(ida_pow10(k) * 128'(m));
		end
	end

	assign rem_ext   = PW'(rem_q);
	assign at_bottom = (pos_q == '0);
	assign pop       = (state_q == ST_IDLE) & ~q_empty;

	always_comb begin
		diff[0] = {1'b0, rem_ext};
		for (int m = 1; m < RADIX; m++) begin
			diff[m] = {1'b0, rem_ext} - {1'b0, mult_tbl[pos_q][m]};
		end
		digit = '0;
		for (int m = 1; m < RADIX; m++) begin
			if (!diff[m][PW]) begin
				digit = DIGIT_W'(m);
			end
		end
		rem_next = diff[digit][VALUE_WIDTH-1:0];
		emit     = (digit != '0) | started_q | at_bottom;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rem_q     <= '0;
			pos_q     <= '0;
			started_q <= 1'b0;
			nl_q      <= 1'b0;
			ch_q      <= '0;
			last_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						rem_q     <= q_mag;
						pos_q     <= TOP_POS;
						started_q <= 1'b0;
						nl_q      <= q_flags.nl;
						state_q   <= q_flags.neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					ch_q     <= CH_MINUS;
					strobe_q <= 1'b1;
					state_q  <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (emit) begin
						ch_q     <= CH_ZERO + CHAR_W'(digit);
						strobe_q <= 1'b1;
						last_q   <= at_bottom & ~nl_q;
					end
					started_q <= started_q | (digit != '0);
					rem_q     <= rem_next;
					if (at_bottom) begin
						state_q <= nl_q ? ST_LF : ST_IDLE;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				ST_LF: begin
					ch_q     <= CH_LF;
					strobe_q <= 1'b1;
					state_q  <= ST_CR;
				end
				ST_CR: begin
					ch_q     <= CH_CR;
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ch     = ch_q;
	assign last   = last_q;
	assign strobe = strobe_q;

endmodule

### hdl/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// The back sequencer steps one decimal position per cycle from the top of the
// value width (10 positions at 32 bits), after an optional minus sign and
// before an optional line end; the front can accept a new number while the
// back is still printing the previous one.
// Front and back are split by a two-entry queue; results cannot be stalled.
// Reset clears all control state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii import ida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [VALUE_FIELD_W-1:0] value,
	input  logic                     is_signed,
	input  logic                     add_newline,
	output logic [CHAR_W-1:0]        ch,
	output logic                     last,
	output logic                     strobe
);

	localparam int DATA_W = VALUE_WIDTH + FLAGS_W;

	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	logic [VALUE_WIDTH-1:0] f_mag;
	ida_flags_t             f_flags;
	logic [DATA_W-1:0]      q_wdata;
	logic [DATA_W-1:0]      q_rdata;
	logic [VALUE_WIDTH-1:0] q_mag;
	ida_flags_t             q_flags;

	assign q_wdata = {f_flags, f_mag};
	assign q_mag   = q_rdata[VALUE_WIDTH-1:0];
	assign q_flags = q_rdata[DATA_W-1:VALUE_WIDTH];

	ida_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.is_signed  (is_signed),
		.add_newline(add_newline),
		.q_full     (q_full),
		.push       (push),
		.mag        (f_mag),
		.flags      (f_flags)
	);

	ida_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.pop   (pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	ida_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_mag  (q_mag),
		.q_flags(q_flags),
		.pop    (pop),
		.ch     (ch),
		.last   (last),
		.strobe (strobe)
	);

endmodule
